// ===== hdl/format_string_decimal_printer_defines.svh =====
// Assertion macros used by the checker of the decimal printer.
// No dependencies.
`ifndef FORMAT_STRING_DECIMAL_PRINTER_DEFINES_SVH
`define FORMAT_STRING_DECIMAL_PRINTER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define FSDP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FSDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fsdp_pkg.sv =====
// Shared types, constants and helper functions of the decimal printer.
// No dependencies.
package fsdp_pkg;

    localparam int CHAR_W         = 8;
    localparam int ARG_IN_W       = 32;
    localparam int COUNT_W        = 16;
    localparam int DEF_ARG_WIDTH  = 32;
    localparam int DIGIT_BITS     = 4;
    localparam int BITS_PER_STEP  = 4;
    localparam int DEC_BASE       = 10;

    localparam logic [COUNT_W-1:0]    COUNT_MAX  = '1;
    localparam logic [CHAR_W-1:0]     ASCII_ZERO = 8'd48;
    localparam logic [CHAR_W-1:0]     CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0]     CH_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0]     CH_D       = 8'h64;
    localparam logic [CHAR_W-1:0]     CH_MINUS   = 8'h2D;
    localparam logic [DIGIT_BITS-1:0] BCD_ADJ_MIN = DIGIT_BITS'(DEC_BASE / 2);
    localparam logic [DIGIT_BITS-1:0] BCD_ADJ     =
        DIGIT_BITS'(((2 ** DIGIT_BITS) - DEC_BASE) / 2);

    // What an accepted byte asks for.
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_ECHO,
        ACT_PERCENT,
        ACT_DECIMAL
    } act_t;

    // Source of an emitted character.
    typedef enum logic [1:0] {
        SEL_CHAR,
        SEL_PERCENT,
        SEL_MINUS,
        SEL_DIGIT
    } sel_t;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic find;
        logic emit;
        sel_t emit_sel;
        logic emit_last;
        logic dig_dec;
    } cmd_t;

    typedef struct packed {
        act_t action;
        logic neg;
        logic conv_last;
        logic dig_last;
        logic out_free;
    } sts_t;

    // Decimal digits needed for a w-bit unsigned value (log10(2) ~ 0.30103).
    function automatic int num_digits(input int w);
        return (w * 30103) / 100000 + 1;
    endfunction

    // Double-dabble correction of one BCD digit.
    function automatic logic [DIGIT_BITS-1:0] bcd_adjust(input logic [DIGIT_BITS-1:0] d);
        return (d >= BCD_ADJ_MIN) ? DIGIT_BITS'(d + BCD_ADJ) : d;
    endfunction

endpackage

// ===== hdl/fsdp_datapath.sv =====
// Datapath of the decimal printer: format state, binary-to-BCD converter,
// digit index and the output word register. Depends on fsdp_pkg.
module fsdp_datapath #(
    parameter int ARG_WIDTH = fsdp_pkg::DEF_ARG_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [fsdp_pkg::CHAR_W-1:0]         s_format_char,
    input  logic signed [fsdp_pkg::ARG_IN_W-1:0] s_argument_value,
    input  logic                                s_format_start,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [fsdp_pkg::CHAR_W-1:0]         m_out_char,
    output logic                                m_last_in_run,
    output logic [fsdp_pkg::COUNT_W-1:0]        m_chars_emitted,
    input  fsdp_pkg::cmd_t                      cmd,
    output fsdp_pkg::sts_t                      sts
);
    import fsdp_pkg::*;

    localparam int STEPS = (ARG_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int PAD_W = STEPS * BITS_PER_STEP;
    localparam int NDIG  = num_digits(ARG_WIDTH);
    localparam int BCD_W = NDIG * DIGIT_BITS;
    localparam int IDX_W = $clog2(NDIG);
    localparam int CNT_W = $clog2(STEPS);

    logic                              pending_reg;
    logic [COUNT_W-1:0]                char_total_reg;
    logic [CHAR_W-1:0]                 char_reg;
    logic                              neg_reg;
    logic [PAD_W-1:0]                  bin_reg;
    logic [NDIG-1:0][DIGIT_BITS-1:0]   bcd_reg;
    logic [CNT_W-1:0]                  conv_cnt_reg;
    logic [IDX_W-1:0]                  dig_idx_reg;
    logic                              m_valid_reg;
    logic [CHAR_W-1:0]                 out_char_reg;
    logic                              last_reg;
    logic [COUNT_W-1:0]                count_reg;

    logic [ARG_WIDTH-1:0]              arg_ext;
    logic [ARG_WIDTH-1:0]              mag;
    logic                              arg_neg;
    logic                              pend_eff;
    logic                              pending_next;
    act_t                              action;
    logic [NDIG-1:0][DIGIT_BITS-1:0]   bcd_next;
    logic [PAD_W-1:0]                  bin_next;
    logic [IDX_W-1:0]                  top_idx;
    logic [CHAR_W-1:0]                 emit_char;
    logic [COUNT_W-1:0]                char_total_next;

    // Low ARG_WIDTH bits, or the whole word zero-extended when wider.
    generate
        if (ARG_WIDTH <= ARG_IN_W) begin : g_narrow
            assign arg_ext = s_argument_value[ARG_WIDTH-1:0];
        end else begin : g_wide
            assign arg_ext = {{(ARG_WIDTH - ARG_IN_W){1'b0}}, s_argument_value};
        end
    endgenerate

    // Unsigned magnitude, so the most negative value converts correctly.
    assign arg_neg = arg_ext[ARG_WIDTH-1];
    assign mag     = arg_neg ? ARG_WIDTH'(~arg_ext + 1'b1) : arg_ext;

    // Classify the byte on the input port.
    assign pend_eff = pending_reg && !s_format_start;

    always_comb begin
        action       = ACT_NONE;
        pending_next = 1'b0;
        if (s_format_char == CH_NUL) begin
            action = ACT_NONE;
        end else if (pend_eff) begin
            if (s_format_char == CH_PERCENT) begin
                action = ACT_PERCENT;
            end else if (s_format_char == CH_D) begin
                action = ACT_DECIMAL;
            end
        end else if (s_format_char == CH_PERCENT) begin
            pending_next = 1'b1;
        end else begin
            action = ACT_ECHO;
        end
    end

    // BITS_PER_STEP double-dabble iterations per cycle.
    always_comb begin
        bcd_next = bcd_reg;
        bin_next = bin_reg;
        for (int s = 0; s < BITS_PER_STEP; s++) begin
            for (int d = 0; d < NDIG; d++) begin
                bcd_next[d] = bcd_adjust(bcd_next[d]);
            end
            bcd_next = BCD_W'({bcd_next, bin_next[PAD_W-1]});
            bin_next = {bin_next[PAD_W-2:0], 1'b0};
        end
    end

    // Most significant non-zero digit; zero gives index 0.
    always_comb begin
        top_idx = '0;
        for (int i = 0; i < NDIG; i++) begin
            if (bcd_reg[i] != '0) begin
                top_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        case (cmd.emit_sel)
            SEL_CHAR:    emit_char = char_reg;
            SEL_PERCENT: emit_char = CH_PERCENT;
            SEL_MINUS:   emit_char = CH_MINUS;
            SEL_DIGIT:   emit_char = ASCII_ZERO + CHAR_W'(bcd_reg[dig_idx_reg]);
            default:     emit_char = char_reg;
        endcase
    end

    assign char_total_next = (char_total_reg == COUNT_MAX) ? COUNT_MAX
                                                           : char_total_reg + 1'b1;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg    <= 1'b0;
            char_total_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.load) begin
                pending_reg <= pending_next;
                if (s_format_start) begin
                    char_total_reg <= '0;
                end
            end else if (cmd.emit) begin
                char_total_reg <= char_total_next;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            char_reg     <= s_format_char;
            neg_reg      <= arg_neg;
            bin_reg      <= PAD_W'(mag);
            bcd_reg      <= '0;
            conv_cnt_reg <= '0;
        end else if (cmd.conv_step) begin
            bin_reg      <= bin_next;
            bcd_reg      <= bcd_next;
            conv_cnt_reg <= conv_cnt_reg + 1'b1;
        end
        if (cmd.find) begin
            dig_idx_reg <= top_idx;
        end else if (cmd.dig_dec) begin
            dig_idx_reg <= dig_idx_reg - 1'b1;
        end
        if (cmd.emit) begin
            out_char_reg <= emit_char;
            last_reg     <= cmd.emit_last;
            count_reg    <= char_total_next;
        end
    end

    assign sts.action    = action;
    assign sts.neg       = neg_reg;
    assign sts.conv_last = (conv_cnt_reg == CNT_W'(STEPS - 1));
    assign sts.dig_last  = (dig_idx_reg == '0);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_out_char      = out_char_reg;
    assign m_last_in_run   = last_reg;
    assign m_chars_emitted = count_reg;

endmodule

// ===== hdl/fsdp_ctrl.sv =====
// Controller of the decimal printer: sequences accept, conversion and
// character emission. Depends on fsdp_pkg.
module fsdp_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output fsdp_pkg::cmd_t cmd,
    input  fsdp_pkg::sts_t sts
);
    import fsdp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ECHO,
        ST_PCT,
        ST_CONV,
        ST_FIND,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_ready_reg;
    logic   s_ready_next;

    always_comb begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.conv_step = 1'b0;
        cmd.find      = 1'b0;
        cmd.emit      = 1'b0;
        cmd.emit_sel  = SEL_CHAR;
        cmd.emit_last = 1'b0;
        cmd.dig_dec   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.load = 1'b1;
                    case (sts.action)
                        ACT_ECHO:    state_next = ST_ECHO;
                        ACT_PERCENT: state_next = ST_PCT;
                        ACT_DECIMAL: state_next = ST_CONV;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ECHO: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = SEL_CHAR;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_PCT: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = SEL_PERCENT;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_CONV: begin
                cmd.conv_step = 1'b1;
                if (sts.conv_last) begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND: begin
                cmd.find   = 1'b1;
                state_next = sts.neg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN: begin
                if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = SEL_MINUS;
                    state_next   = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = SEL_DIGIT;
                    cmd.emit_last = sts.dig_last;
                    cmd.dig_dec   = 1'b1;
                    if (sts.dig_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready_next = (state_next == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

    assign s_ready = s_ready_reg;

endmodule

// ===== hdl/format_string_decimal_printer.sv =====
// Top level of the format-string decimal printer: controller plus datapath.
// Depends on fsdp_pkg, fsdp_ctrl and fsdp_datapath.
//
//   Channel | Direction | Word contents
//   s_      | in        | format_char, argument_value, format_start
//   m_      | out       | out_char, last_in_run, chars_emitted
//
// Steps: a plain byte or "%%" is accepted, then emitted; '%', NUL or an unknown
// conversion is only accepted. "%d" is accepted, runs STEPS = ceil(ARG_WIDTH/4)
// converter passes, finds the top digit, emits an optional sign, then the digits.
// Reset is synchronous, active low; s_ready rises the cycle after release.
// A stalled m_ready holds the output word and freezes emission; the next input
// word is taken once the item's last character sits in the output register.
module format_string_decimal_printer #(
    parameter int ARG_WIDTH = fsdp_pkg::DEF_ARG_WIDTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [fsdp_pkg::CHAR_W-1:0]          s_format_char,
    input  logic signed [fsdp_pkg::ARG_IN_W-1:0] s_argument_value,
    input  logic                                 s_format_start,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [fsdp_pkg::CHAR_W-1:0]          m_out_char,
    output logic                                 m_last_in_run,
    output logic [fsdp_pkg::COUNT_W-1:0]         m_chars_emitted
);
    import fsdp_pkg::*;

    // command and status between controller and datapath
    cmd_t cmd;
    sts_t sts;

    // State machine: accept, convert, then one character per free output slot.
    fsdp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Pending-percent flag, character total, converter and output register.
    fsdp_datapath #(
        .ARG_WIDTH (ARG_WIDTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_format_char    (s_format_char),
        .s_argument_value (s_argument_value),
        .s_format_start   (s_format_start),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_out_char       (m_out_char),
        .m_last_in_run    (m_last_in_run),
        .m_chars_emitted  (m_chars_emitted),
        .cmd              (cmd),
        .sts              (sts)
    );

endmodule

// ===== hdl/fsdp_checker.sv =====
// Port-level assertions for the decimal printer, bound to the top level.
// Depends on format_string_decimal_printer_defines.svh.
`include "format_string_decimal_printer_defines.svh"

module fsdp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_char,
    input logic        m_last_in_run,
    input logic [15:0] m_chars_emitted
);

    // A stalled output word holds.
    `FSDP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_char) && $stable(m_last_in_run) && $stable(m_chars_emitted), "output word changed while stalled")

    // No new input word while an item still has characters to send.
    `FSDP_ASSERT_SAME(a_busy_mid_run, aclk, aresetn, m_valid && !m_last_in_run, !s_ready, "input taken in the middle of a run")

    // Within a run the count steps by one or sits at saturation.
    `FSDP_ASSERT_NEXT(a_count_step, aclk, aresetn, m_valid && m_ready && !m_last_in_run, !m_valid || (m_chars_emitted == $past(m_chars_emitted) + 16'd1) || (m_chars_emitted == 16'hFFFF), "character count not consecutive")

    // Every emitted character counts itself.
    `FSDP_ASSERT_SAME(a_count_nonzero, aclk, aresetn, m_valid, m_chars_emitted != 16'd0, "zero character count on output")

endmodule

bind format_string_decimal_printer fsdp_checker u_fsdp_checker (.*);
